// ===== design/tqe_pkg.sv =====
`default_nettype none
package tqe_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DELETED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FIRED    = 3'd4;
  localparam logic [2:0] ST_NOFIRE   = 3'd5;

  localparam logic [31:0] INTERVAL_RESET = 32'd100000;

  typedef struct packed {
    logic [62:0] expiry;
    logic [31:0] id;
    logic [63:0] payload;
  } entry_t;

  typedef struct packed {
    logic         we;
    logic [5:0]   waddr;
    entry_t       wdata;
  } mem_wr_t;

endpackage
`default_nettype wire

// ===== design/timer_queue_expiry_top.sv =====
`default_nettype none
// add, non-qualifying tick: result in the cycle after start, next start accepted at once
// delete: one pass over the entry memory (one read per cycle)
// qualifying tick: one memory pass per fired timer, plus one more pass
// results are single-cycle strobes on result_valid; the receiver cannot stall
// rst (synchronous) clears all valid bits, next id to 1, last check to 0, interval to 100000
module timer_queue_expiry_top #(
  parameter int CAPACITY = 32
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         kind,
  input  wire  [61:0]        now_time,
  input  wire  [31:0]        delay,
  input  wire  signed [63:0] payload,
  input  wire  [31:0]        target_id,
  input  wire                cfg_wr_en,
  input  wire  [31:0]        cfg_wr_data,
  output logic               result_valid,
  output logic [2:0]         status,
  output logic [31:0]        timer_id,
  output logic signed [63:0] fired_payload,
  output logic               last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  tqe_pkg::state_t state, state_next;

  logic [CAPACITY-1:0] valid;
  logic [31:0]         next_id;
  logic [61:0]         last_check;
  logic [31:0]         check_interval;

  logic                op_del;
  logic [61:0]         op_now;
  logic [31:0]         op_target;

  logic [AW-1:0]       scan_addr;
  logic                issuing;
  logic                rd_v;
  logic [AW-1:0]       rd_idx;
  tqe_pkg::entry_t     rd_data;

  logic                have;
  logic [AW-1:0]       best_idx;
  tqe_pkg::entry_t     best;
  logic                pend;
  tqe_pkg::entry_t     pend_e;

  logic                free_found;
  logic [AW-1:0]       free_idx;
  logic                accept;
  logic                tick_due;
  logic [62:0]         chk_sum;
  logic                cand;
  logic                better;
  logic                scan_done;
  tqe_pkg::entry_t     wr_entry;
  logic                mem_we;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  assign accept   = start && !busy;
  assign chk_sum  = {1'b0, last_check} + {31'd0, check_interval};
  assign tick_due = {1'b0, now_time} > chk_sum;

  assign wr_entry.expiry  = {1'b0, now_time} + {31'd0, delay};
  assign wr_entry.id      = next_id;
  assign wr_entry.payload = payload;
  assign mem_we = accept && (kind == tqe_pkg::KIND_ADD) && free_found;

  tqe_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (free_idx),
    .wdata (wr_entry),
    .raddr (scan_addr),
    .rdata (rd_data)
  );

  // entry qualifies and beats the current best (expiry, then id, then lower slot)
  always_comb begin
    cand = valid[rd_idx] && (op_del ? (rd_data.id == op_target)
                                    : (rd_data.expiry <= {1'b0, op_now}));
    better = !have || (rd_data.expiry < best.expiry) ||
             ((rd_data.expiry == best.expiry) && (rd_data.id < best.id));
  end

  assign scan_done = rd_v && (rd_idx == LAST_IDX);

  always_comb begin
    state_next = state;
    unique case (state)
      tqe_pkg::ST_IDLE: begin
        if (accept && ((kind == tqe_pkg::KIND_DEL) ||
                       ((kind == tqe_pkg::KIND_TICK) && tick_due))) begin
          state_next = tqe_pkg::ST_SCAN;
        end
      end
      tqe_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = tqe_pkg::ST_FIN;
        end
      end
      tqe_pkg::ST_FIN: begin
        if (!op_del && have) begin
          state_next = tqe_pkg::ST_SCAN;
        end else begin
          state_next = tqe_pkg::ST_IDLE;
        end
      end
      default: state_next = tqe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      tqe_pkg::ST_IDLE: busy = 1'b0;
      tqe_pkg::ST_SCAN: busy = 1'b1;
      tqe_pkg::ST_FIN:  busy = 1'b1;
      default:          busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tqe_pkg::ST_IDLE;
      valid          <= '0;
      next_id        <= 32'd1;
      last_check     <= '0;
      check_interval <= tqe_pkg::INTERVAL_RESET;
      result_valid   <= 1'b0;
      issuing        <= 1'b0;
      rd_v           <= 1'b0;
      have           <= 1'b0;
      pend           <= 1'b0;
      scan_addr      <= '0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      rd_v         <= issuing;
      rd_idx       <= scan_addr;
      if (cfg_wr_en) begin
        check_interval <= cfg_wr_data;
      end

      unique case (state)
        tqe_pkg::ST_IDLE: begin
          if (accept) begin
            op_del    <= (kind == tqe_pkg::KIND_DEL);
            op_now    <= now_time;
            op_target <= target_id;
            scan_addr <= '0;
            issuing   <= 1'b1;
            have      <= 1'b0;
            pend      <= 1'b0;
            status        <= tqe_pkg::ST_NOFIRE;
            timer_id      <= '0;
            fired_payload <= '0;
            last          <= 1'b1;
            unique case (kind)
              tqe_pkg::KIND_ADD: begin
                issuing      <= 1'b0;
                result_valid <= 1'b1;
                if (free_found) begin
                  valid[free_idx] <= 1'b1;
                  status          <= tqe_pkg::ST_ADDED;
                  timer_id        <= next_id;
                  next_id <= (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
                end else begin
                  status <= tqe_pkg::ST_FULL;
                end
              end
              tqe_pkg::KIND_DEL: begin
              end
              tqe_pkg::KIND_TICK: begin
                if (!tick_due) begin
                  issuing      <= 1'b0;
                  result_valid <= 1'b1;
                end
              end
              default: begin
                issuing <= 1'b0;
              end
            endcase
          end
        end
        tqe_pkg::ST_SCAN: begin
          if (issuing) begin
            scan_addr <= scan_addr + AW'(1);
            if (scan_addr == LAST_IDX) begin
              issuing <= 1'b0;
            end
          end
          if (rd_v && cand && better) begin
            have     <= 1'b1;
            best     <= rd_data;
            best_idx <= rd_idx;
          end
        end
        tqe_pkg::ST_FIN: begin
          if (op_del) begin
            result_valid  <= 1'b1;
            status        <= have ? tqe_pkg::ST_DELETED : tqe_pkg::ST_NOTFOUND;
            timer_id      <= '0;
            fired_payload <= '0;
            last          <= 1'b1;
            if (have) begin
              valid[best_idx] <= 1'b0;
            end
          end else begin
            // the fired entry found on the previous pass goes out now, once we know if more follow
            if (pend) begin
              result_valid  <= 1'b1;
              status        <= tqe_pkg::ST_FIRED;
              timer_id      <= pend_e.id;
              fired_payload <= pend_e.payload;
              last          <= !have;
            end else if (!have) begin
              result_valid  <= 1'b1;
              status        <= tqe_pkg::ST_NOFIRE;
              timer_id      <= '0;
              fired_payload <= '0;
              last          <= 1'b1;
            end
            if (have) begin
              valid[best_idx] <= 1'b0;
              pend      <= 1'b1;
              pend_e    <= best;
              have      <= 1'b0;
              scan_addr <= '0;
              issuing   <= 1'b1;
            end else begin
              last_check <= op_now;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/tqe_mem.sv =====
`default_nettype none
module tqe_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire                    clk,
  input  wire                    we,
  input  wire [AW-1:0]           waddr,
  input  wire tqe_pkg::entry_t   wdata,
  input  wire [AW-1:0]           raddr,
  output tqe_pkg::entry_t        rdata
);

  tqe_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/tqe_checker.sv =====
`default_nettype none
module tqe_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire [1:0]  kind,
  input wire        result_valid,
  input wire [2:0]  status,
  input wire [31:0] timer_id,
  input wire [63:0] fired_payload,
  input wire        last
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !result_valid)
    else $error("block not idle after reset");

  a_add_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == tqe_pkg::KIND_ADD |=> result_valid && last)
    else $error("add transaction gave no result in the next cycle");

  a_fired_id: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == tqe_pkg::ST_FIRED |-> timer_id != 32'd0)
    else $error("fired timer with id zero");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != tqe_pkg::ST_FIRED |-> fired_payload == 64'd0)
    else $error("payload on a non-fire result");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != tqe_pkg::ST_FIRED |-> last)
    else $error("non-fire result not marked last");

endmodule

bind timer_queue_expiry_top tqe_checker u_tqe_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .kind          (kind),
  .result_valid  (result_valid),
  .status        (status),
  .timer_id      (timer_id),
  .fired_payload (fired_payload),
  .last          (last)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int           CAPACITY    = 32;
  localparam logic [1:0]   KIND_UNUSED = 2'd3;
  localparam int           IDLE_LIMIT  = 4000;
  localparam logic [61:0]  TIME_MAX    = {62{1'b1}};

  typedef struct {
    logic [2:0]  status;
    logic [31:0] id;
    logic [63:0] payload;
    logic        is_last;
  } timer_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         kind = '0;
  logic [61:0]        now_time = '0;
  logic [31:0]        delay = '0;
  logic signed [63:0] payload = '0;
  logic [31:0]        target_id = '0;
  logic               cfg_wr_en = 1'b0;
  logic [31:0]        cfg_wr_data = '0;
  logic               busy;
  logic               result_valid;
  logic [2:0]         status;
  logic [31:0]        timer_id;
  logic signed [63:0] fired_payload;
  logic               last;

  // predictor state
  logic        slot_valid [CAPACITY];
  logic [62:0] slot_expiry [CAPACITY];
  logic [31:0] slot_id [CAPACITY];
  logic [63:0] slot_payload [CAPACITY];
  logic [31:0] id_counter;
  logic [61:0] last_check_time;
  logic [31:0] check_gap;

  timer_result_t pending_results[$];
  int          error_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          timers_fired = 0;
  int          idle_cycles = 0;
  logic [61:0] sim_now = '0;

  timer_queue_expiry_top #(.CAPACITY(CAPACITY)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .now_time(now_time), .delay(delay), .payload(payload), .target_id(target_id),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data), .result_valid(result_valid),
    .status(status), .timer_id(timer_id), .fired_payload(fired_payload), .last(last)
  );

  always #5 clk = ~clk;

  function automatic bit fires_first(int a, int b);
    if (slot_expiry[a] != slot_expiry[b]) return slot_expiry[a] < slot_expiry[b];
    if (slot_id[a] != slot_id[b]) return slot_id[a] < slot_id[b];
    return a < b;
  endfunction

  task automatic push_result(logic [2:0] st, logic [31:0] id, logic [63:0] pay,
                             logic lst);
    timer_result_t r;
    r.status = st;
    r.id = id;
    r.payload = pay;
    r.is_last = lst;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic predict_timer_op(logic [1:0] k, logic [61:0] t, logic [31:0] d,
                                  logic [63:0] p, logic [31:0] tgt);
    int slot;
    int best;
    int fired;
    slot = -1;
    best = -1;
    fired = 0;
    case (k)
      tqe_pkg::KIND_ADD: begin
        for (int i = 0; i < CAPACITY; i++)
          if (!slot_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          push_result(tqe_pkg::ST_FULL, '0, '0, 1'b1);
        end else begin
          slot_valid[slot] = 1'b1;
          slot_expiry[slot] = {1'b0, t} + {31'd0, d};
          slot_id[slot] = id_counter;
          slot_payload[slot] = p;
          push_result(tqe_pkg::ST_ADDED, id_counter, '0, 1'b1);
          id_counter = id_counter + 32'd1;
          if (id_counter == '0) id_counter = 32'd1;
        end
      end
      tqe_pkg::KIND_DEL: begin
        for (int i = 0; i < CAPACITY; i++)
          if (slot_valid[i] && slot_id[i] == tgt && (best < 0 || fires_first(i, best)))
            best = i;
        if (best < 0) begin
          push_result(tqe_pkg::ST_NOTFOUND, '0, '0, 1'b1);
        end else begin
          slot_valid[best] = 1'b0;
          push_result(tqe_pkg::ST_DELETED, '0, '0, 1'b1);
        end
      end
      tqe_pkg::KIND_TICK: begin
        if ({1'b0, t} <= {1'b0, last_check_time} + {31'd0, check_gap}) begin
          push_result(tqe_pkg::ST_NOFIRE, '0, '0, 1'b1);
        end else begin
          do begin
            best = -1;
            for (int i = 0; i < CAPACITY; i++)
              if (slot_valid[i] && slot_expiry[i] <= {1'b0, t} &&
                  (best < 0 || fires_first(i, best)))
                best = i;
            if (best >= 0) begin
              slot_valid[best] = 1'b0;
              push_result(tqe_pkg::ST_FIRED, slot_id[best], slot_payload[best], 1'b0);
              fired++;
            end
          end while (best >= 0);
          last_check_time = t;
          if (fired == 0) push_result(tqe_pkg::ST_NOFIRE, '0, '0, 1'b1);
          else pending_results[pending_results.size() - 1].is_last = 1'b1;
          timers_fired += fired;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [1:0] k, logic [61:0] t, logic [31:0] d,
                           logic [63:0] p, logic [31:0] tgt);
    int gap;
    kind <= k;
    now_time <= t;
    delay <= d;
    payload <= p;
    target_id <= tgt;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_timer_op(k, t, d, p, tgt);
    if (k != KIND_UNUSED) items_sent++;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every expected result is in, then let a delete scan drain
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 * CAPACITY) @(posedge clk);
  endtask

  task automatic write_interval(logic [31:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    check_gap = v;
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    timer_result_t exp_r;
    if (!rst && result_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d", status));
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status)
          report_mismatch($sformatf("status %0d exp %0d", status, exp_r.status));
        if (timer_id !== exp_r.id)
          report_mismatch($sformatf("timer_id %0d exp %0d", timer_id, exp_r.id));
        if (fired_payload !== exp_r.payload)
          report_mismatch($sformatf("payload %h exp %h", fired_payload, exp_r.payload));
        if (last !== exp_r.is_last)
          report_mismatch($sformatf("last %b exp %b", last, exp_r.is_last));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_directed();
    send_item(tqe_pkg::KIND_TICK, 62'd0, '0, '0, '0);           // inside interval
    send_item(tqe_pkg::KIND_TICK, 62'd100001, '0, '0, '0);      // qualifies, nothing due
    send_item(tqe_pkg::KIND_ADD, 62'd100001, 32'd0, 64'h7fffffffffffffff, '0);
    send_item(tqe_pkg::KIND_ADD, 62'd100001, 32'hffffffff, 64'h8000000000000000, '0);
    send_item(tqe_pkg::KIND_ADD, 62'd100002, 32'd10, 64'hffffffffffffffff, '0);
    send_item(tqe_pkg::KIND_ADD, 62'd100002, 32'd10, 64'd0, '0);
    send_item(tqe_pkg::KIND_DEL, '0, '0, '0, 32'd0);            // id zero never held
    send_item(tqe_pkg::KIND_DEL, '0, '0, '0, 32'hffffffff);
    send_item(tqe_pkg::KIND_DEL, '0, '0, '0, 32'd3);
    send_item(tqe_pkg::KIND_DEL, '0, '0, '0, 32'd3);            // already gone
    send_item(KIND_UNUSED, 62'd5, 32'd5, 64'd5, 32'd1);
    send_item(tqe_pkg::KIND_TICK, 62'd150000, '0, '0, '0);      // too early
    send_item(tqe_pkg::KIND_TICK, 62'd200002, '0, '0, '0);      // fires ids 1 and 4
    sim_now = 62'd200002;
  endtask

  task automatic test_full_table();
    write_interval(32'd0);
    for (int i = 0; i <= CAPACITY; i++)
      send_item(tqe_pkg::KIND_ADD, sim_now, $urandom_range(0, 3), rand64(), '0);
    sim_now = sim_now + 62'd10;
    send_item(tqe_pkg::KIND_TICK, sim_now, '0, '0, '0);
  endtask

  task automatic test_random_ops(logic [31:0] ival, int n, bit mid_pause);
    int r;
    logic [31:0] tgt;
    write_interval(ival);
    for (int i = 0; i < n; i++) begin
      if (mid_pause && i == n / 2) wait_idle();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_item(tqe_pkg::KIND_ADD,
                  ($urandom_range(0, 9) == 0) ? sim_now + $urandom_range(0, 50)
                  : sim_now, $urandom_range(0, 2 * ival + 2000), rand64(), rand64());
      end else if (r < 70) begin
        tgt = ($urandom_range(0, 9) == 0) ? $urandom() : id_counter - $urandom_range(1, 10);
        send_item(tqe_pkg::KIND_DEL, 62'(rand64()), $urandom(), rand64(), tgt);
      end else if (r < 97) begin
        sim_now = sim_now + $urandom_range(0, 2 * ival + 1000);
        send_item(tqe_pkg::KIND_TICK, sim_now, $urandom(), rand64(), $urandom());
      end else begin
        send_item(KIND_UNUSED, 62'(rand64()), $urandom(), rand64(), $urandom());
      end
    end
  endtask

  task automatic test_extremes();
    write_interval(32'hffffffff);
    send_item(tqe_pkg::KIND_ADD, TIME_MAX, 32'hffffffff, rand64(), '0);
    send_item(tqe_pkg::KIND_ADD, TIME_MAX, 32'd0, rand64(), '0);
    send_item(tqe_pkg::KIND_TICK, sim_now + 62'd1, '0, '0, '0);
    // everything due except the max-expiry timer
    send_item(tqe_pkg::KIND_TICK, TIME_MAX, '0, '0, '0);
    send_item(tqe_pkg::KIND_TICK, TIME_MAX, '0, '0, '0);
    send_item(tqe_pkg::KIND_DEL, '0, '0, '0, id_counter - 32'd2);
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) slot_valid[i] = 1'b0;
    id_counter = 32'd1;
    last_check_time = '0;
    check_gap = tqe_pkg::INTERVAL_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random_ops(32'd0, 80, 1'b0);
    test_random_ops(32'd300, 90, 1'b1);
    test_random_ops($urandom_range(1, 2000), 90, 1'b0);
    test_random_ops(tqe_pkg::INTERVAL_RESET, 60, 1'b0);
    test_extremes();
    wait_idle();
    $display("sent %0d items over add/delete/tick, %0d results checked, %0d timers fired",
             items_sent, results_seen, timers_fired);
    $display("intervals covered: reset value, zero, small, random and all ones");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== timer_queue_expiry_top.f =====
design/tqe_pkg.sv
design/tqe_mem.sv
design/timer_queue_expiry_top.sv
design/tqe_checker.sv
sim/tb_top.sv
